@@ hw/rtl/nes_pkg.sv @@
// Package for the nearest-entry sorted search: sizes, codes and state types.
`default_nettype none
package nes_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IW          = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW          = $clog2(TABLE_DEPTH + 1);
    localparam int NIW         = 10;
    localparam int VW          = 32;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNSORTED = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOP,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/nes_ram.sv @@
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module nes_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/nearest_entry_sorted_search.sv @@
// Top level: sorted table store with binary nearest-entry search.
//
// One input channel: a word is taken at a rising edge with start high and
// busy low. i_func selects load (append i_value, i_first_entry restarts the
// table) or query (find the entry nearest to i_value).
// A load gives no result, and busy stays low.
// A query on an empty or unsorted table gives its result in the cycle after
// acceptance with index 0 and an error status, busy stays low.
// Other queries raise busy: one table read per binary-search step, issued
// back to back through the registered RAM read port, then, unless the
// search ends at either end of the table, one read of the lower
// neighbor and a final distance compare; the result word is out in the
// cycle in which busy falls.
// A result is on o_nearest_index/o_status for one cycle with o_strobe high;
// the receiver cannot stall it. A new word may be taken during that cycle.
// Reset empties the table (count zero, unsorted flag clear); the RAM
// contents are not cleared and need no clearing pass.
`default_nettype none
module nearest_entry_sorted_search (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_func,
    input  wire logic signed [31:0] i_value,
    input  wire logic              i_first_entry,
    output logic                   o_strobe,
    output logic             [9:0] o_nearest_index,
    output logic             [1:0] o_status
);
    import nes_pkg::*;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic signed [VW-1:0] r_prev, n_prev;
    logic                 r_unsorted, n_unsorted;
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_hi, n_hi;
    logic [CW-1:0]        r_mid, n_mid;
    logic signed [VW-1:0] r_target, n_target;
    logic signed [VW-1:0] r_above, n_above;
    logic                 r_strobe, n_strobe;
    logic [NIW-1:0]       r_index, n_index;
    t_status              r_status, n_status;

    logic                 accept;
    logic                 ram_we, ram_re;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [VW-1:0]        ram_rdata;
    logic signed [VW-1:0] entry;
    logic signed [VW:0]   dist_below, dist_above;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign entry  = $signed(ram_rdata);

    nes_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VW),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_prev     = r_prev;
        n_unsorted = r_unsorted;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_target   = r_target;
        n_above    = r_above;
        n_strobe   = 1'b0;
        n_index    = r_index;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_waddr  = r_count[IW-1:0];
        ram_re     = 1'b0;
        ram_raddr  = r_mid[IW-1:0];
        dist_below = '0;
        dist_above = '0;

        case (r_state)
            S_IDLE: begin
                if (accept && i_func == FUNC_LOAD) begin
                    if (i_first_entry) begin
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        n_count    = CW'(1);
                        n_unsorted = 1'b0;
                        n_prev     = i_value;
                    end else if (r_count < CW'(TABLE_DEPTH)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[IW-1:0];
                        n_count   = r_count + CW'(1);
                        n_prev    = i_value;
                        if (r_count != '0 && i_value < r_prev) begin
                            n_unsorted = 1'b1;
                        end
                    end
                end else if (accept && i_func == FUNC_QUERY) begin
                    if (r_count == '0) begin
                        n_strobe = 1'b1;
                        n_index  = '0;
                        n_status = ST_EMPTY;
                    end else if (r_unsorted) begin
                        n_strobe = 1'b1;
                        n_index  = '0;
                        n_status = ST_UNSORTED;
                    end else begin
                        n_target  = i_value;
                        n_lo      = '0;
                        n_hi      = r_count;
                        n_mid     = r_count >> 1;
                        ram_re    = 1'b1;
                        ram_raddr = n_mid[IW-1:0];
                        n_state   = S_LOOP;
                    end
                end
            end
            S_LOOP: begin
                if (entry > r_target) begin
                    n_hi    = r_mid;
                    n_above = entry;
                end else begin
                    n_lo = r_mid + CW'(1);
                end
                n_mid = n_lo + ((n_hi - n_lo) >> 1);
                if (n_lo < n_hi) begin
                    ram_re    = 1'b1;
                    ram_raddr = n_mid[IW-1:0];
                end else if (n_lo >= r_count) begin
                    n_strobe = 1'b1;
                    n_index  = NIW'(r_count - CW'(1));
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else if (n_lo == '0) begin
                    n_strobe = 1'b1;
                    n_index  = '0;
                    n_status = ST_OK;
                    n_state  = S_IDLE;
                end else begin
                    // fetch the lower neighbor; the upper one is held in r_above
                    n_mid     = n_lo - CW'(1);
                    ram_re    = 1'b1;
                    ram_raddr = n_mid[IW-1:0];
                    n_state   = S_FIN;
                end
            end
            S_FIN: begin
                dist_below = (VW+1)'(r_target) - (VW+1)'(entry);
                dist_above = (VW+1)'(r_above) - (VW+1)'(r_target);
                n_strobe   = 1'b1;
                n_status   = ST_OK;
                n_index    = (dist_below < dist_above) ? NIW'(r_mid) : NIW'(r_lo);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_prev     <= '0;
            r_unsorted <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_prev     <= n_prev;
            r_unsorted <= n_unsorted;
            r_strobe   <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_above  <= n_above;
        r_index  <= n_index;
        r_status <= n_status;
    end

    assign o_strobe        = r_strobe;
    assign o_nearest_index = r_index;
    assign o_status        = r_status;

endmodule
`default_nettype wire

@@ hw/rtl/nes_chk.sv @@
// Port-level checker for the nearest-entry sorted search, bound to the top level.
`default_nettype none
module nes_chk (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              i_func,
    input wire logic signed [31:0] i_value,
    input wire logic              i_first_entry,
    input wire logic              o_strobe,
    input wire logic        [9:0] o_nearest_index,
    input wire logic        [1:0] o_status
);
    import nes_pkg::*;

    // a result word only appears once the search has released the input side
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result word while busy");

    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_QUERY) |=> (busy || o_strobe))
        else $error("query word neither searched nor answered");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FUNC_LOAD) |=> (!o_strobe && !busy))
        else $error("load word produced a result or stalled");

    a_error_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_nearest_index == '0))
        else $error("error status with nonzero index");

endmodule

bind nearest_entry_sorted_search nes_chk u_nes_chk (.*);
`default_nettype wire

@@ verif/nearest_entry_sorted_search_tb.sv @@
// Testbench for nearest_entry_sorted_search: directed and random load/query words.
module nearest_entry_sorted_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nes_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 450;
    localparam int TAIL_CYCLES  = 20;

    localparam logic signed [VW-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VW-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint Q_MAX = 64'sd2147483647;

    typedef struct packed {
        logic [NIW-1:0] index;
        t_status        status;
    } t_answer;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  start         = 1'b0;
    logic                  busy;
    logic                  i_func        = FUNC_LOAD;
    logic signed [VW-1:0]  i_value       = '0;
    logic                  i_first_entry = 1'b0;
    logic                  o_strobe;
    logic [NIW-1:0]        o_nearest_index;
    logic [1:0]            o_status;

    // shadow copy of the block state
    logic signed [VW-1:0]  shadow_table [TABLE_DEPTH];
    int                    shadow_count    = 0;
    logic                  shadow_unsorted = 1'b0;
    logic signed [VW-1:0]  shadow_prev     = '0;

    t_answer               pending_answers [$];
    int                    mismatches  = 0;
    int                    cycles      = 0;
    int                    burst_left  = 0;
    int                    words_sent  = 0;

    nearest_entry_sorted_search dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_value         (i_value),
        .i_first_entry   (i_first_entry),
        .o_strobe        (o_strobe),
        .o_nearest_index (o_nearest_index),
        .o_status        (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_answer want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected result word: index %0d status %0d",
                       o_nearest_index, o_status);
                mismatches++;
            end else begin
                want = pending_answers.pop_front();
                if (o_nearest_index !== want.index) begin
                    $error("nearest_index: expected %0d, got %0d", want.index, o_nearest_index);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    function automatic t_answer nearest_answer(input logic signed [VW-1:0] target);
        t_answer ans;
        int      lo;
        int      hi;
        int      mid;
        longint  below;
        longint  above;
        ans.index  = '0;
        ans.status = ST_OK;
        if (shadow_count == 0) begin
            ans.status = ST_EMPTY;
        end else if (shadow_unsorted) begin
            ans.status = ST_UNSORTED;
        end else begin
            lo = 0;
            hi = shadow_count;
            while (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                if (shadow_table[mid] > target) hi = mid;
                else lo = mid + 1;
            end
            if (lo >= shadow_count) begin
                ans.index = NIW'(shadow_count - 1);
            end else if (lo > 0) begin
                below = longint'(target) - longint'(shadow_table[lo-1]);
                above = longint'(shadow_table[lo]) - longint'(target);
                ans.index = (below < above) ? NIW'(lo - 1) : NIW'(lo);
            end
        end
        return ans;
    endfunction

    // one word through the start/busy handshake, bursts with random gaps
    task automatic send_word(input logic func, input logic signed [VW-1:0] value,
                             input logic first);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        start         <= 1'b1;
        i_func        <= func;
        i_value       <= value;
        i_first_entry <= first;
        do @(posedge i_clk); while (busy !== 1'b0);
        words_sent++;
        if (func == FUNC_LOAD) begin
            if (first) begin
                shadow_count    = 0;
                shadow_unsorted = 1'b0;
            end
            if (shadow_count < TABLE_DEPTH) begin
                if (shadow_count > 0 && value < shadow_prev) shadow_unsorted = 1'b1;
                shadow_table[shadow_count] = value;
                shadow_count++;
                shadow_prev = value;
            end
        end else begin
            pending_answers = {pending_answers, nearest_answer(value)};
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_answers.size() != 0);
    endtask

    task automatic load_sorted_run(input int n, input longint base, input int unsigned max_step);
        longint v;
        v = base;
        for (int i = 0; i < n; i++) begin
            send_word(FUNC_LOAD, VW'(v), i == 0);
            if ($urandom_range(0, 7) != 0) v += longint'($urandom_range(0, max_step));
            if (v > Q_MAX) v = Q_MAX;
        end
    endtask

    task automatic query_near_entries(input int m);
        int     idx;
        longint anchor;
        longint t;
        for (int i = 0; i < m; i++) begin
            if (shadow_count == 0) begin
                t = longint'($signed($urandom()));
            end else begin
                idx    = $urandom_range(0, shadow_count - 1);
                anchor = longint'(shadow_table[idx]);
                case ($urandom_range(0, 5))
                    0: t = anchor;
                    1: t = anchor + 1;
                    2: t = anchor - 1;
                    3: t = (idx + 1 < shadow_count) ?
                           (anchor + longint'(shadow_table[idx+1])) >>> 1 : anchor + 3;
                    4: t = anchor + longint'($urandom_range(0, 65535)) - 32768;
                    default: t = longint'($signed($urandom()));
                endcase
            end
            if (t > Q_MAX) t = Q_MAX;
            if (t < Q_MIN) t = Q_MIN;
            send_word(FUNC_QUERY, VW'(t), logic'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_empty_table();
        send_word(FUNC_QUERY, 32'sd0, 1'b0);
        send_word(FUNC_QUERY, VAL_MIN, 1'b1);
    endtask

    task automatic test_first_load_without_flag();
        send_word(FUNC_LOAD, 32'sh0005_0000, 1'b0);
        send_word(FUNC_QUERY, 32'sd0, 1'b0);
        send_word(FUNC_QUERY, VAL_MAX, 1'b0);
    endtask

    task automatic test_extreme_values_and_ties();
        send_word(FUNC_LOAD, VAL_MIN, 1'b1);
        send_word(FUNC_LOAD, VAL_MAX, 1'b0);
        send_word(FUNC_QUERY, VAL_MIN, 1'b0);
        send_word(FUNC_QUERY, VAL_MAX, 1'b0);
        send_word(FUNC_QUERY, -32'sd1, 1'b0);
        send_word(FUNC_QUERY, 32'sd0, 1'b0);
        // midpoints, one of them next to a duplicate
        send_word(FUNC_LOAD, 32'sd0, 1'b1);
        send_word(FUNC_LOAD, 32'sh0002_0000, 1'b0);
        send_word(FUNC_LOAD, 32'sh0002_0000, 1'b0);
        send_word(FUNC_LOAD, 32'sh0004_0000, 1'b0);
        send_word(FUNC_QUERY, 32'sh0001_0000, 1'b0);
        send_word(FUNC_QUERY, 32'sh0003_0000, 1'b0);
        send_word(FUNC_QUERY, 32'sh0002_0000, 1'b0);
        send_word(FUNC_QUERY, -32'sd5, 1'b0);
    endtask

    task automatic test_unsorted_table();
        send_word(FUNC_LOAD, 32'sh000a_0000, 1'b1);
        send_word(FUNC_LOAD, 32'sh0005_0000, 1'b0);
        send_word(FUNC_QUERY, 32'sh0005_0000, 1'b0);
        send_word(FUNC_LOAD, 32'sh0014_0000, 1'b0);
        send_word(FUNC_QUERY, 32'sh0014_0000, 1'b0);
        send_word(FUNC_LOAD, 32'sh0001_0000, 1'b1);
        send_word(FUNC_QUERY, 32'sd0, 1'b0);
    endtask

    task automatic test_full_table();
        load_sorted_run(TABLE_DEPTH, Q_MIN, 32'd1 << 20);
        send_word(FUNC_LOAD, VAL_MIN, 1'b0);
        send_word(FUNC_LOAD, VAL_MAX, 1'b0);
        send_word(FUNC_QUERY, VAL_MAX, 1'b0);
        send_word(FUNC_QUERY, VAL_MIN, 1'b0);
        query_near_entries(8);
        send_word(FUNC_LOAD, 32'sd0, 1'b1);
        send_word(FUNC_QUERY, VAL_MAX, 1'b0);
    endtask

    task automatic test_random_traffic();
        int     first_word;
        longint base;
        int     n;
        first_word = words_sent;
        while (words_sent - first_word < RANDOM_WORDS) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 6))
                        send_word(logic'($urandom_range(0, 1)), $signed($urandom()),
                                  $urandom_range(0, 3) == 0);
                end
                2: begin
                    send_word(FUNC_LOAD, shadow_prev + VW'($urandom_range(0, 1000)), 1'b0);
                    query_near_entries($urandom_range(1, 4));
                end
                default: begin
                    base = ($urandom_range(0, 3) == 0) ? Q_MIN : longint'($signed($urandom()));
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 200)
                                                    : $urandom_range(1, 32);
                    case ($urandom_range(0, 3))
                        0: load_sorted_run(n, base, 16);
                        1: load_sorted_run(n, base, 65536);
                        2: load_sorted_run(n, base, 32'd1 << 24);
                        default: load_sorted_run(n, base, 32'hffff_ffff);
                    endcase
                    query_near_entries($urandom_range(1, 12));
                end
            endcase
            if ($urandom_range(0, 19) == 0) drain_results();
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_first_load_without_flag();
        test_extreme_values_and_ties();
        test_unsorted_table();
        test_full_table();
        drain_results();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
